// ===== hdl/pairwise_dissimilarity_engine_unit_defines.svh =====
// Assertion macros shared by the pairwise dissimilarity engine RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef PAIRWISE_DISSIMILARITY_ENGINE_UNIT_DEFINES_SVH
`define PAIRWISE_DISSIMILARITY_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication check
`define PDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pde check failed");
// Next-cycle implication check
`define PDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pde check failed");
`else
`define PDE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PDE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/pde_pkg.sv =====
// Shared types and constants of the pairwise dissimilarity engine.
// No dependencies; used by pde_ctrl, pde_datapath and the top level.
package pde_pkg;

  // Metric register codes
  localparam logic [2:0] MET_JACCARD      = 3'd0;
  localparam logic [2:0] MET_JACCARD_TURN = 3'd1;
  localparam logic [2:0] MET_SORENSEN     = 3'd2;
  localparam logic [2:0] MET_SIMPSON      = 3'd3;
  localparam logic [2:0] MET_BRAY         = 3'd4;
  localparam logic [2:0] MET_BRAY_TURN    = 3'd5;

  localparam int         FRAC_BITS = 16;
  localparam int         STEP_W    = 4;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;
  localparam logic [16:0] Q_ONE    = 17'h10000;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic acc_en;   // item accepted: accumulate
    logic load;     // last item accepted: latch operands, clear accumulators
    logic step;     // one quotient bit
    logic finish;   // final quotient bit, register result
  } cmd_t;

endpackage

// ===== hdl/pde_ctrl.sv =====
// Controller of the pairwise dissimilarity engine: handshakes and divide sequencing.
// Depends on pde_pkg and the assertion macro header.
`include "pairwise_dissimilarity_engine_unit_defines.svh"
module pde_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_species,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output pde_pkg::cmd_t cmd
);

  pde_pkg::state_t             state_r, state_nxt;
  logic [pde_pkg::STEP_W-1:0]  step_cnt_r, step_cnt_nxt;
  logic                        in_acc;

  // Out of reset, non-last items flow any time; a last item waits until the controller is idle
  assign in_ready  = rst_n && (!in_last_species || (state_r == pde_pkg::ST_IDLE));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state_r == pde_pkg::ST_HOLD);

  // Datapath commands
  always_comb begin
    cmd.acc_en = in_acc;
    cmd.load   = in_acc && in_last_species;
    cmd.step   = (state_r == pde_pkg::ST_DIV);
    cmd.finish = (state_r == pde_pkg::ST_DIV) && (step_cnt_r == pde_pkg::STEP_LAST);
  end

  // Next state
  always_comb begin
    state_nxt    = state_r;
    step_cnt_nxt = step_cnt_r;
    case (state_r)
      pde_pkg::ST_IDLE: begin
        step_cnt_nxt = '0;
        if (cmd.load) state_nxt = pde_pkg::ST_DIV;
      end
      pde_pkg::ST_DIV: begin
        step_cnt_nxt = step_cnt_r + 1'b1;
        if (cmd.finish) state_nxt = pde_pkg::ST_HOLD;
      end
      pde_pkg::ST_HOLD: begin
        if (out_ready) state_nxt = pde_pkg::ST_IDLE;
      end
      default: begin
        state_nxt    = pde_pkg::ST_IDLE;
        step_cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pde_pkg::ST_IDLE;
      step_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

  // Checks
  `PDE_ASSERT_NEXT(a_load_starts_div, clk, rst_n, cmd.load, state_r == pde_pkg::ST_DIV)
  `PDE_ASSERT_NEXT(a_finish_gives_result, clk, rst_n, cmd.finish, out_valid)
  `PDE_ASSERT_NOW(a_last_only_when_idle, clk, rst_n, cmd.load, !cmd.step && !out_valid)

endmodule

// ===== hdl/pde_datapath.sv =====
// Datapath of the pairwise dissimilarity engine: accumulators, operand select,
// restoring divider and result register. Depends on pde_pkg and the macro header.
`include "pairwise_dissimilarity_engine_unit_defines.svh"
module pde_datapath #(
  parameter int MAX_SPECIES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pde_pkg::cmd_t cmd,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_metric,
  input  logic [15:0]   abund_a,
  input  logic [15:0]   abund_b,
  output logic [16:0]   dissimilarity,
  output logic          zero_denominator
);

  localparam longint unsigned CNT_CAP_L = 64'(MAX_SPECIES);
  localparam longint unsigned SUM_CAP_L = 64'(MAX_SPECIES) * 64'd65535;
  localparam int CNT_W = $clog2(CNT_CAP_L + 1);
  localparam int SUM_W = $clog2(SUM_CAP_L + 1);
  localparam int DEN_W = SUM_W + 1;
  localparam logic [CNT_W:0] CNT_CAP = (CNT_W+1)'(CNT_CAP_L);
  localparam logic [SUM_W:0] SUM_CAP = (SUM_W+1)'(SUM_CAP_L);

  // Saturating accumulate helpers
  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] acc, input logic inc);
    logic [CNT_W:0] s;
    s = {1'b0, acc} + (CNT_W+1)'(inc);
    sat_cnt = (s > CNT_CAP) ? CNT_CAP[CNT_W-1:0] : s[CNT_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                               input logic [15:0] inc);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(inc);
    sat_sum = (s > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : s[SUM_W-1:0];
  endfunction

  logic [2:0]         metric_r;
  logic [CNT_W-1:0]   cnt_a_r, cnt_b_r, cnt_both_r;
  logic [CNT_W-1:0]   cnt_a_nxt, cnt_b_nxt, cnt_both_nxt;
  logic [SUM_W-1:0]   sum_a_r, sum_b_r, sum_min_r, sum_diff_r, sum_max_r;
  logic [SUM_W-1:0]   sum_a_nxt, sum_b_nxt, sum_min_nxt, sum_diff_nxt, sum_max_nxt;
  logic               pres_a, pres_b;
  logic [15:0]        lo, hi;
  logic [DEN_W-1:0]   ab, num_sel, den_sel;
  logic               inv_sel, unused_sel;
  logic [DEN_W-1:0]   den_r, rem_r;
  logic [DEN_W:0]     rem_sh;
  logic               ge;
  logic [pde_pkg::FRAC_BITS-1:0] q_r, q_nxt;
  logic               inv_r, unused_r, zero_r, full_r;
  logic [16:0]        res_nxt, dissim_r;

  // Metric register
  always_ff @(posedge clk) begin
    if (!rst_n)         metric_r <= pde_pkg::MET_JACCARD;
    else if (cfg_valid) metric_r <= cfg_metric;
  end

  // Per-item accumulate, current item included
  always_comb begin
    pres_a       = |abund_a;
    pres_b       = |abund_b;
    lo           = (abund_a < abund_b) ? abund_a : abund_b;
    hi           = (abund_a < abund_b) ? abund_b : abund_a;
    cnt_a_nxt    = sat_cnt(cnt_a_r, pres_a && !pres_b);
    cnt_b_nxt    = sat_cnt(cnt_b_r, !pres_a && pres_b);
    cnt_both_nxt = sat_cnt(cnt_both_r, pres_a && pres_b);
    sum_a_nxt    = sat_sum(sum_a_r, abund_a);
    sum_b_nxt    = sat_sum(sum_b_r, abund_b);
    sum_min_nxt  = sat_sum(sum_min_r, lo);
    sum_diff_nxt = sat_sum(sum_diff_r, hi - lo);
    sum_max_nxt  = sat_sum(sum_max_r, hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      cnt_a_r    <= '0;
      cnt_b_r    <= '0;
      cnt_both_r <= '0;
      sum_a_r    <= '0;
      sum_b_r    <= '0;
      sum_min_r  <= '0;
      sum_diff_r <= '0;
      sum_max_r  <= '0;
    end else if (cmd.acc_en) begin
      cnt_a_r    <= cnt_a_nxt;
      cnt_b_r    <= cnt_b_nxt;
      cnt_both_r <= cnt_both_nxt;
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      sum_min_r  <= sum_min_nxt;
      sum_diff_r <= sum_diff_nxt;
      sum_max_r  <= sum_max_nxt;
    end
  end

  // Operand select; numerator never exceeds denominator
  always_comb begin
    ab         = DEN_W'(cnt_a_nxt) + DEN_W'(cnt_b_nxt);
    num_sel    = '0;
    den_sel    = '0;
    inv_sel    = 1'b0;
    unused_sel = 1'b0;
    case (metric_r)
      pde_pkg::MET_JACCARD: begin
        num_sel = DEN_W'(cnt_both_nxt);
        den_sel = ab + DEN_W'(cnt_both_nxt);
        inv_sel = 1'b1;
      end
      pde_pkg::MET_JACCARD_TURN: begin
        num_sel = ab;
        den_sel = ab + DEN_W'(cnt_both_nxt);
      end
      pde_pkg::MET_SORENSEN: begin
        num_sel = DEN_W'(cnt_both_nxt) << 1;
        den_sel = ab + (DEN_W'(cnt_both_nxt) << 1);
        inv_sel = 1'b1;
      end
      pde_pkg::MET_SIMPSON: begin
        num_sel = DEN_W'(sum_min_nxt);
        den_sel = (sum_a_nxt < sum_b_nxt) ? DEN_W'(sum_a_nxt) : DEN_W'(sum_b_nxt);
        inv_sel = 1'b1;
      end
      pde_pkg::MET_BRAY: begin
        num_sel = DEN_W'(sum_diff_nxt);
        den_sel = DEN_W'(sum_a_nxt) + DEN_W'(sum_b_nxt);
      end
      pde_pkg::MET_BRAY_TURN: begin
        num_sel = DEN_W'(sum_diff_nxt);
        den_sel = DEN_W'(sum_max_nxt);
      end
      default: unused_sel = 1'b1;
    endcase
  end

  // Restoring divider step: one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r, 1'b0};
    ge     = (rem_sh >= {1'b0, den_r});
    q_nxt  = {q_r[pde_pkg::FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_r    <= den_sel;
      rem_r    <= num_sel;
      q_r      <= '0;
      inv_r    <= inv_sel;
      unused_r <= unused_sel;
      zero_r   <= (den_sel == '0) && !unused_sel;
      full_r   <= (num_sel >= den_sel);
    end else if (cmd.step) begin
      rem_r <= ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      q_r   <= q_nxt;
    end
  end

  // Final value: unused codes give zero; zero denominator reads as ratio zero, full ratio as one
  always_comb begin
    if (unused_r)    res_nxt = '0;
    else if (zero_r) res_nxt = inv_r ? pde_pkg::Q_ONE : 17'd0;
    else if (full_r) res_nxt = inv_r ? 17'd0 : pde_pkg::Q_ONE;
    else if (inv_r)  res_nxt = pde_pkg::Q_ONE - {1'b0, q_nxt};
    else             res_nxt = {1'b0, q_nxt};
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) dissim_r <= res_nxt;
  end

  assign dissimilarity    = dissim_r;
  assign zero_denominator = zero_r;

  // Checks
  `PDE_ASSERT_NEXT(a_result_in_range, clk, rst_n, cmd.finish, dissim_r <= pde_pkg::Q_ONE)
  `PDE_ASSERT_NEXT(a_zero_den_extreme, clk, rst_n, cmd.finish, !zero_r || dissim_r == 17'd0 || dissim_r == pde_pkg::Q_ONE)
  `PDE_ASSERT_NEXT(a_load_clears_counts, clk, rst_n, cmd.load, cnt_a_r == '0 && cnt_both_r == '0 && sum_a_r == '0)

endmodule

// ===== hdl/pairwise_dissimilarity_engine_unit.sv =====
// Pairwise dissimilarity engine, top level.
// Input channel: one species per item (abundance in site A and B, last flag).
// Result channel: one Q1.16 dissimilarity (65536 = one) and a zero-denominator
// flag per vector pair, emitted after the item marked last_species.
// Config channel: 3-bit metric (0 Jaccard, 1 Jaccard turnover, 2 Sorensen,
// 3 Simpson, 4 Bray-Curtis, 5 Bray-Curtis turnover); cfg_ready is high out of reset.
// Throughput: one species item per cycle while in_ready is high. A restoring
// divider produces one quotient bit per cycle and registers the result with
// the final bit. Items of the next vector keep flowing during the divide; only
// its last item waits until the previous result has been taken.
// Receiver stall: the result holds in its register; non-last items still
// accumulate, the next last item is held off.
// Reset (synchronous, rst_n low): accumulators clear, metric returns to
// Jaccard, no result pending, in_ready and cfg_ready low. Counts saturate at
// MAX_SPECIES, sums at MAX_SPECIES * 65535, without a flag.
module pairwise_dissimilarity_engine_unit #(
  parameter int MAX_SPECIES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_abund_a,
  input  logic [15:0] in_abund_b,
  input  logic        in_last_species,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_dissimilarity,
  output logic        out_zero_denominator,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_metric
);

  pde_pkg::cmd_t cmd;

  assign cfg_ready = rst_n;

  // Sequencer
  pde_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_species (in_last_species),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cmd             (cmd)
  );

  // Accumulators and divider
  pde_datapath #(
    .MAX_SPECIES (MAX_SPECIES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_valid        (cfg_valid),
    .cfg_metric       (cfg_metric),
    .abund_a          (in_abund_a),
    .abund_b          (in_abund_b),
    .dissimilarity    (out_dissimilarity),
    .zero_denominator (out_zero_denominator)
  );

endmodule

// ===== sim/pairwise_dissimilarity_engine_unit_tb.sv =====
// Self-checking bench for the pairwise dissimilarity engine: random and directed
// species streams, metric sweeps, back-pressure, checked against a local predictor.
// Depends on pde_pkg and pairwise_dissimilarity_engine_unit.
`timescale 1ns / 100ps

module pairwise_dissimilarity_engine_unit_tb;

  localparam int          SPECIES_CAP   = 1024;
  localparam longint      COUNT_CAP     = longint'(SPECIES_CAP);
  localparam longint      SUM_CAP       = longint'(SPECIES_CAP) * 65535;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          LONG_HOLD     = 300;
  localparam int          DRAIN_LIMIT   = 5000;
  localparam logic [15:0] ABUND_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic        last;
  } species_item_t;

  typedef struct packed {
    logic [16:0] diss;
    logic        zden;
  } diss_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_abund_a = '0;
  logic [15:0] in_abund_b = '0;
  logic        in_last_species = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] out_dissimilarity;
  logic        out_zero_denominator;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_metric = pde_pkg::MET_JACCARD;

  // Pending species items and expected dissimilarities
  species_item_t species_q[$];
  diss_result_t  diss_expected_q[$];

  // Predictor state, mirrors the accumulators of the block
  logic [2:0]  metric_now = pde_pkg::MET_JACCARD;
  logic [16:0] n_a_only = '0;
  logic [16:0] n_b_only = '0;
  logic [16:0] n_both = '0;
  logic [31:0] s_first = '0;
  logic [31:0] s_second = '0;
  logic [31:0] s_min = '0;
  logic [31:0] s_absdiff = '0;
  logic [31:0] s_max = '0;

  // Idling controls and bookkeeping
  logic        send_idle = 1'b1;
  logic        recv_idle = 1'b1;
  int          feed_gap = 0;
  int          take_gap = 0;
  int          hold_trigger = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;
  int unsigned metric_writes = 0;

  pairwise_dissimilarity_engine_unit #(
    .MAX_SPECIES(SPECIES_CAP)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_abund_a(in_abund_a),
    .in_abund_b(in_abund_b),
    .in_last_species(in_last_species),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_dissimilarity(out_dissimilarity),
    .out_zero_denominator(out_zero_denominator),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_metric(cfg_metric)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Timeout at %0t, run did not drain", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [31:0] inc,
                                          input longint cap);
    longint s;
    s = longint'(acc) + longint'(inc);
    return (s > cap) ? 32'(cap) : 32'(s);
  endfunction

  // Truncated Q1.16 ratio, clamped to one; den is nonzero here
  function automatic logic [16:0] q16_ratio(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    q = (num << pde_pkg::FRAC_BITS) / den;
    return (q > 64'(pde_pkg::Q_ONE)) ? pde_pkg::Q_ONE : q[16:0];
  endfunction

  // Fold one species into the predictor; on the last one, queue the dissimilarity
  task automatic tally_species(input logic [15:0] a, input logic [15:0] b, input logic last);
    logic [15:0]  lo;
    logic [15:0]  hi;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [63:0]  pair_only;
    logic [16:0]  q;
    logic         one_minus;
    diss_result_t r;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (a != 0 && b == 0) n_a_only = 17'(sat_add(32'(n_a_only), 32'd1, COUNT_CAP));
    if (a == 0 && b != 0) n_b_only = 17'(sat_add(32'(n_b_only), 32'd1, COUNT_CAP));
    if (a != 0 && b != 0) n_both = 17'(sat_add(32'(n_both), 32'd1, COUNT_CAP));
    s_first = sat_add(s_first, 32'(a), SUM_CAP);
    s_second = sat_add(s_second, 32'(b), SUM_CAP);
    s_min = sat_add(s_min, 32'(lo), SUM_CAP);
    s_absdiff = sat_add(s_absdiff, 32'(hi - lo), SUM_CAP);
    s_max = sat_add(s_max, 32'(hi), SUM_CAP);
    if (last) begin
      pair_only = 64'(n_a_only) + 64'(n_b_only);
      one_minus = 1'b0;
      num = '0;
      den = 64'd1;
      case (metric_now)
        pde_pkg::MET_JACCARD: begin
          num = 64'(n_both);
          den = pair_only + 64'(n_both);
          one_minus = 1'b1;
        end
        pde_pkg::MET_JACCARD_TURN: begin
          num = pair_only;
          den = pair_only + 64'(n_both);
        end
        pde_pkg::MET_SORENSEN: begin
          num = 2 * 64'(n_both);
          den = pair_only + 2 * 64'(n_both);
          one_minus = 1'b1;
        end
        pde_pkg::MET_SIMPSON: begin
          num = 64'(s_min);
          den = (s_first < s_second) ? 64'(s_first) : 64'(s_second);
          one_minus = 1'b1;
        end
        pde_pkg::MET_BRAY: begin
          num = 64'(s_absdiff);
          den = 64'(s_first) + 64'(s_second);
        end
        pde_pkg::MET_BRAY_TURN: begin
          num = 64'(s_absdiff);
          den = 64'(s_max);
        end
        default: ;
      endcase
      r.zden = (den == 0);
      q = r.zden ? 17'd0 : q16_ratio(num, den);
      r.diss = one_minus ? pde_pkg::Q_ONE - q : q;
      diss_expected_q.push_back(r);
      n_a_only = '0;
      n_b_only = '0;
      n_both = '0;
      s_first = '0;
      s_second = '0;
      s_min = '0;
      s_absdiff = '0;
      s_max = '0;
    end
  endtask

  // Wait per item, skewed toward short gaps
  function automatic int draw_gap();
    return int'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2));
  endfunction

  function automatic logic [15:0] draw_abund();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'd0;
      3:       return ABUND_MAX;
      4:       return 16'($urandom_range(1, 3));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Input driver: offers queued items, predicts on acceptance
  always @(posedge clk) begin : feed_proc
    species_item_t nxt;
    logic          offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && !in_ready) stall_cycles++;
      if (in_valid && in_ready) begin
        tally_species(in_abund_a, in_abund_b, in_last_species);
        items_accepted++;
        offer = 1'b0;
        feed_gap = send_idle ? draw_gap() : 0;
      end
      if (!offer) begin
        if (feed_gap > 0) begin
          feed_gap--;
        end else if (species_q.size() > 0) begin
          nxt = species_q.pop_front();
          in_abund_a <= nxt.a;
          in_abund_b <= nxt.b;
          in_last_species <= nxt.last;
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin : hold_proc
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_trigger) begin
      hold_left <= LONG_HOLD;
      hold_served <= hold_trigger;
    end
  end

  // Result monitor: compare against the oldest expectation
  always @(posedge clk) begin : result_proc
    diss_result_t want;
    logic         take;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (diss_expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, dissimilarity %0d zero_denominator %0b",
                   $time, out_dissimilarity, out_zero_denominator);
        end else begin
          want = diss_expected_q.pop_front();
          if (out_dissimilarity !== want.diss) begin
            mismatches++;
            $display("%0t: dissimilarity expected %0d actual %0d",
                     $time, want.diss, out_dissimilarity);
          end
          if (out_zero_denominator !== want.zden) begin
            mismatches++;
            $display("%0t: zero_denominator expected %0b actual %0b",
                     $time, want.zden, out_zero_denominator);
          end
        end
        take_gap = recv_idle ? draw_gap() : 0;
      end
      take = 1'b1;
      if (hold_left != 0) begin
        take = 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        take = 1'b0;
      end
      out_ready <= take;
    end
  end

  task automatic push_species(input logic [15:0] a, input logic [15:0] b, input logic last);
    species_item_t it;
    it.a = a;
    it.b = b;
    it.last = last;
    species_q.push_back(it);
  endtask

  task automatic set_metric(input logic [2:0] code);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_metric <= code;
    do @(posedge clk); while (!cfg_ready);
    metric_now = code;
    cfg_valid <= 1'b0;
    metric_writes++;
    @(negedge clk);
  endtask

  // Block is idle once everything is accepted and answered; a settling margin follows
  task automatic wait_idle();
    do @(negedge clk); while (species_q.size() != 0 || in_valid || diss_expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Short vector with random content; returns its length
  task automatic queue_vector(output int len);
    case ($urandom_range(0, 9))
      0, 1:    len = 1;
      9:       len = $urandom_range(20, 40);
      default: len = $urandom_range(2, 12);
    endcase
    for (int i = 0; i < len; i++) push_species(draw_abund(), draw_abund(), i == len - 1);
  endtask

  initial begin : stimulus
    int n;
    int len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty vector (zero denominator for the used codes) and field extremes for every code,
    // the two unused codes included
    for (int m = 0; m < 8; m++) begin
      set_metric(3'(m));
      push_species(16'd0, 16'd0, 1'b1);
      case (3'(m))
        pde_pkg::MET_JACCARD: begin
          push_species(ABUND_MAX, 16'd0, 1'b0);
          push_species(ABUND_MAX, ABUND_MAX, 1'b1);
        end
        pde_pkg::MET_JACCARD_TURN: begin
          push_species(16'd0, ABUND_MAX, 1'b0);
          push_species(16'd1, 16'd1, 1'b1);
        end
        pde_pkg::MET_SORENSEN: begin
          push_species(ABUND_MAX, ABUND_MAX, 1'b0);
          push_species(16'd0, 16'd1, 1'b1);
        end
        pde_pkg::MET_SIMPSON: begin
          // one site empty: zero denominator despite a nonempty vector
          push_species(ABUND_MAX, 16'd0, 1'b0);
          push_species(16'd0, 16'd0, 1'b1);
        end
        pde_pkg::MET_BRAY: begin
          push_species(ABUND_MAX, 16'd1, 1'b0);
          push_species(16'd1, ABUND_MAX, 1'b1);
        end
        default: begin
          push_species(16'd0, ABUND_MAX, 1'b0);
          push_species(ABUND_MAX, 16'd0, 1'b1);
        end
      endcase
      wait_idle();
    end

    // Random phases: metric sweep from the top code down, then random codes
    for (int p = 0; p < 12; p++) begin
      set_metric((p < 6) ? 3'(5 - p) : 3'($urandom_range(0, 5)));
      send_idle = (p % 3 != 0);
      recv_idle = (p % 4 != 1);
      n = 0;
      while (n < 40) begin
        queue_vector(len);
        n += len;
      end
      wait_idle();
    end

    // Back-pressure: receiver holds off while short vectors stream in
    set_metric(3'($urandom_range(0, 5)));
    send_idle = 1'b0;
    recv_idle = 1'b1;
    hold_trigger++;
    for (int v = 0; v < 25; v++) begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) push_species(draw_abund(), draw_abund(), i == len - 1);
    end
    wait_idle();

    // Final drain with a bound
    n = 0;
    while (diss_expected_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (diss_expected_q.size() != 0) begin
      mismatches += diss_expected_q.size();
      $display("%0t: %0d expected results never arrived", $time, diss_expected_q.size());
    end

    $display("Ran %0d species items into %0d dissimilarities across %0d metric writes,",
             items_accepted, results_seen, metric_writes);
    $display("covering every metric code, a long receiver hold and %0d cycles of input stall.",
             stall_cycles);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
